@@ rtl/dct_pkg.sv @@
// Shared types and constants for the disk collision time block.
`timescale 1ns / 1ps

package dct_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 31;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DISK_RADIUS = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] BOX_LENGTH_RST  = 31'd1048576;
	localparam logic [CFG_W-1:0] DISK_RADIUS_RST = 31'd32768;

	typedef struct packed {
		logic [39:0]        time_a;
		logic signed [31:0] pos_x_a;
		logic signed [31:0] pos_y_a;
		logic signed [31:0] vel_x_a;
		logic signed [31:0] vel_y_a;
		logic [39:0]        time_b;
		logic signed [31:0] pos_x_b;
		logic signed [31:0] pos_y_b;
		logic signed [31:0] vel_x_b;
		logic signed [31:0] vel_y_b;
	} in_word_t;

	typedef struct packed {
		logic        hit;
		logic [39:0] contact_time;
		logic        time_overflow;
	} out_word_t;

endpackage

@@ rtl/disk_collision_time.sv @@
// Pipelined contact time prediction for two disks in a periodic 2D box.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one disk pair word:
//   time stamp, position and velocity of disk a and disk b. The output channel
//   (out_valid / out_stall / out_data) returns one word per pair: hit flag,
//   absolute contact time (Q24.16) and a saturation flag.
//   box_length and disk_radius are written through cfg_wr_en / cfg_idx /
//   cfg_wdata while no pair is in flight.
// Throughput: one pair per cycle while in_stall is low.
// Pipeline: the square root (one root bit per stage, 64 stages) and the divider
//   (one setup stage, then one quotient bit per stage, 41 stages) sit behind
//   13 stages of advance, wrap and wide products, plus the final time stage
//   and the output register.
// Reset: arst_n clears all valid bits and loads the register defaults
//   (box 16.0, radius 0.5). No pair is held afterwards.
// Stall: a two-word output buffer absorbs the pipeline; while out_stall holds
//   the first word, the next finished word parks in the skid slot and
//   in_stall rises, freezing the pipeline until the output drains.

module disk_collision_time import dct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data
);

	typedef struct packed {
		logic         hit;
		logic [62:0]  bm;
		logic [62:0]  v2;
		logic [39:0]  tmax;
		logic [65:0]  rem;
		logic [63:0]  root;
		logic [127:0] n;
	} sq_stage_t;

	typedef struct packed {
		logic        hit;
		logic        fwd;
		logic        ovq;
		logic [62:0] v2;
		logic [39:0] tmax;
		logic [62:0] rem;
		logic [40:0] q;
		logic [40:0] nb;
	} dv_stage_t;

	localparam logic [40:0] QS_SAT   = 41'h100_0000_0000;
	localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;

	function automatic logic signed [31:0] sat_vel(input logic signed [32:0] v);
		if (v > 33'sd2147483647)
			return 32'sd2147483647;
		else if (v < -33'sd2147483647)
			return -32'sd2147483647;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return v[31] ? ~u + 32'd1 : u;
	endfunction

	// minimum image, one correction, then clamp to +-(2^31-1)
	function automatic logic signed [31:0] wrap_sat(input logic signed [58:0] d,
			input logic [30:0] len);
		logic [58:0]        m;
		logic signed [59:0] w;
		logic signed [59:0] l;
		m = d[58] ? -d : d;
		w = {d[58], d};
		l = {29'd0, len};
		if ({m, 1'b0} >= {29'd0, len})
			w = (d > 0) ? w - l : w + l;
		if (w > 60'sd2147483647)
			return 32'sd2147483647;
		else if (w < -60'sd2147483647)
			return -32'sd2147483647;
		else
			return w[31:0];
	endfunction

	logic [CFG_W-1:0] box_len_q, radius_q;
	logic en;
	logic skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_len_q <= BOX_LENGTH_RST;
			radius_q  <= DISK_RADIUS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_BOX_LENGTH:  box_len_q <= cfg_wdata;
				REG_DISK_RADIUS: radius_q  <= cfg_wdata;
			endcase
		end
	end

	// ---------------- front stages ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	logic [39:0] tmax_s1, tmax_s2, tmax_s3, tmax_s4, tmax_s5, tmax_s6;
	logic [39:0] tmax_s7, tmax_s8, tmax_s9, tmax_s10, tmax_s11, tmax_s12;
	logic [39:0] dta_s1, dtb_s1;
	logic signed [31:0] p_s1 [4];
	logic signed [31:0] p_s2 [4];
	logic signed [31:0] p_s3 [4];
	logic [31:0] vm_s1 [4];
	logic        vn_s1 [4];
	logic        vn_s2 [4];
	logic        vn_s3 [4];
	logic [51:0] pl_s2 [4];
	logic [51:0] ph_s2 [4];
	logic [55:0] disp_s3 [4];
	logic signed [57:0] adv_s4 [4];
	logic signed [31:0] vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3;
	logic signed [31:0] vx_s4, vy_s4, vx_s5, vy_s5, vx_s6, vy_s6;
	logic signed [58:0] dx_s5, dy_s5;
	logic signed [31:0] rx_s6, ry_s6;
	logic signed [63:0] bxa_s7, bya_s7;
	logic [61:0] rxx_s7, ryy_s7, vxx_s7, vyy_s7, fr_s7;
	logic signed [63:0] b_s8;
	logic [62:0] r2_s8, v2_s8, r2_s9, v2_s9, v2_s10, v2_s11, v2_s12;
	logic [63:0] fr4_s8, fr4_s9;
	logic        go_s9, go_s10, go_s11, go_s12;
	logic [62:0] bm_s9, bm_s10, bm_s11, bm_s12;
	logic [63:0] bb_ll_s10, vf_ll_s10, vf_lh_s10, vr_ll_s10;
	logic [62:0] bb_lh_s10, vf_hl_s10, vf_hh_s10, vr_lh_s10, vr_hl_s10;
	logic [61:0] bb_hh_s10, vr_hh_s10;
	logic [127:0] bb_s11, vf_s11, vr_s11, pos_s12, neg_s12;

	logic [39:0] tmax_c;
	logic signed [31:0] pin_c [4];
	logic signed [31:0] vin_c [4];
	logic [71:0] dsum_c [4];
	logic signed [63:0] rxx_c, ryy_c, vxx_c, vyy_c;
	logic [61:0] fr_c;
	logic signed [63:0] nb_c;
	logic [127:0] bb_c, vf_c, vr_c;
	logic [128:0] dif_c;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_comb begin
		tmax_c = (in_data.time_a > in_data.time_b) ? in_data.time_a : in_data.time_b;
		pin_c[0] = in_data.pos_x_a;
		pin_c[1] = in_data.pos_y_a;
		pin_c[2] = in_data.pos_x_b;
		pin_c[3] = in_data.pos_y_b;
		vin_c[0] = in_data.vel_x_a;
		vin_c[1] = in_data.vel_y_a;
		vin_c[2] = in_data.vel_x_b;
		vin_c[3] = in_data.vel_y_b;
		for (int i = 0; i < 4; i++)
			dsum_c[i] = (72'(ph_s2[i]) << 20) + 72'(pl_s2[i]);
		rxx_c = rx_s6 * rx_s6;
		ryy_c = ry_s6 * ry_s6;
		vxx_c = vx_s6 * vx_s6;
		vyy_c = vy_s6 * vy_s6;
		fr_c  = radius_q * radius_q;
		nb_c  = -b_s8;
		bb_c  = 128'(bb_ll_s10) + (128'(bb_lh_s10) << 33) + (128'(bb_hh_s10) << 64);
		vf_c  = 128'(vf_ll_s10) + (128'(vf_lh_s10) << 32) + (128'(vf_hl_s10) << 32)
			+ (128'(vf_hh_s10) << 64);
		vr_c  = 128'(vr_ll_s10) + (128'(vr_lh_s10) << 32) + (128'(vr_hl_s10) << 32)
			+ (128'(vr_hh_s10) << 64);
		dif_c = {1'b0, pos_s12} - {1'b0, neg_s12};
	end

	logic sq_v [0:64];
	sq_stage_t sq_s [0:64];
	logic dv_v [0:41];
	dv_stage_t dv_s [0:41];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
			sq_v[0] <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			v_s10   <= v_s9;
			v_s11   <= v_s10;
			v_s12   <= v_s11;
			sq_v[0] <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: later time stamp, time steps, velocity magnitudes, relative velocity
			tmax_s1 <= tmax_c;
			dta_s1  <= tmax_c - in_data.time_a;
			dtb_s1  <= tmax_c - in_data.time_b;
			for (int i = 0; i < 4; i++) begin
				p_s1[i]  <= pin_c[i];
				vm_s1[i] <= mag32(vin_c[i]);
				vn_s1[i] <= vin_c[i][31];
			end
			vx_s1 <= sat_vel({in_data.vel_x_b[31], in_data.vel_x_b}
				- {in_data.vel_x_a[31], in_data.vel_x_a});
			vy_s1 <= sat_vel({in_data.vel_y_b[31], in_data.vel_y_b}
				- {in_data.vel_y_a[31], in_data.vel_y_a});

			// s2: dt * |v| as two 20 x 32 partial products
			tmax_s2 <= tmax_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			for (int i = 0; i < 4; i++) begin
				p_s2[i]  <= p_s1[i];
				vn_s2[i] <= vn_s1[i];
				pl_s2[i] <= (i < 2 ? dta_s1[19:0] : dtb_s1[19:0]) * vm_s1[i];
				ph_s2[i] <= (i < 2 ? dta_s1[39:20] : dtb_s1[39:20]) * vm_s1[i];
			end

			// s3: displacement truncated to Q40.16
			tmax_s3 <= tmax_s2;
			vx_s3   <= vx_s2;
			vy_s3   <= vy_s2;
			for (int i = 0; i < 4; i++) begin
				p_s3[i]    <= p_s2[i];
				vn_s3[i]   <= vn_s2[i];
				disp_s3[i] <= dsum_c[i][71:16];
			end

			// s4: advanced positions
			tmax_s4 <= tmax_s3;
			vx_s4   <= vx_s3;
			vy_s4   <= vy_s3;
			for (int i = 0; i < 4; i++)
				adv_s4[i] <= vn_s3[i] ? {{26{p_s3[i][31]}}, p_s3[i]} - {2'b00, disp_s3[i]}
					: {{26{p_s3[i][31]}}, p_s3[i]} + {2'b00, disp_s3[i]};

			// s5: separation b - a
			tmax_s5 <= tmax_s4;
			vx_s5   <= vx_s4;
			vy_s5   <= vy_s4;
			dx_s5   <= {adv_s4[2][57], adv_s4[2]} - {adv_s4[0][57], adv_s4[0]};
			dy_s5   <= {adv_s4[3][57], adv_s4[3]} - {adv_s4[1][57], adv_s4[1]};

			// s6: periodic wrap
			tmax_s6 <= tmax_s5;
			vx_s6   <= vx_s5;
			vy_s6   <= vy_s5;
			rx_s6   <= wrap_sat(dx_s5, box_len_q);
			ry_s6   <= wrap_sat(dy_s5, box_len_q);

			// s7: 32 x 32 products
			tmax_s7 <= tmax_s6;
			bxa_s7  <= rx_s6 * vx_s6;
			bya_s7  <= ry_s6 * vy_s6;
			rxx_s7  <= rxx_c[61:0];
			ryy_s7  <= ryy_c[61:0];
			vxx_s7  <= vxx_c[61:0];
			vyy_s7  <= vyy_c[61:0];
			fr_s7   <= fr_c;

			// s8: b, |r|^2, |v|^2, 4R^2
			tmax_s8 <= tmax_s7;
			b_s8    <= bxa_s7 + bya_s7;
			r2_s8   <= {1'b0, rxx_s7} + {1'b0, ryy_s7};
			v2_s8   <= {1'b0, vxx_s7} + {1'b0, vyy_s7};
			fr4_s8  <= {fr_s7, 2'b00};

			// s9: approach test, -b
			tmax_s9 <= tmax_s8;
			go_s9   <= b_s8[63] && (v2_s8 != '0);
			bm_s9   <= nb_c[62:0];
			v2_s9   <= v2_s8;
			r2_s9   <= r2_s8;
			fr4_s9  <= fr4_s8;

			// s10: 32 x 32 partials of b^2, v2*4R^2, v2*r2
			tmax_s10  <= tmax_s9;
			go_s10    <= go_s9;
			bm_s10    <= bm_s9;
			v2_s10    <= v2_s9;
			bb_ll_s10 <= bm_s9[31:0] * bm_s9[31:0];
			bb_lh_s10 <= bm_s9[31:0] * bm_s9[62:32];
			bb_hh_s10 <= bm_s9[62:32] * bm_s9[62:32];
			vf_ll_s10 <= v2_s9[31:0] * fr4_s9[31:0];
			vf_lh_s10 <= v2_s9[31:0] * fr4_s9[63:32];
			vf_hl_s10 <= v2_s9[62:32] * fr4_s9[31:0];
			vf_hh_s10 <= v2_s9[62:32] * fr4_s9[63:32];
			vr_ll_s10 <= v2_s9[31:0] * r2_s9[31:0];
			vr_lh_s10 <= v2_s9[31:0] * r2_s9[62:32];
			vr_hl_s10 <= v2_s9[62:32] * r2_s9[31:0];
			vr_hh_s10 <= v2_s9[62:32] * r2_s9[62:32];

			// s11: assemble wide products
			tmax_s11 <= tmax_s10;
			go_s11   <= go_s10;
			bm_s11   <= bm_s10;
			v2_s11   <= v2_s10;
			bb_s11   <= bb_c;
			vf_s11   <= vf_c;
			vr_s11   <= vr_c;

			// s12
			tmax_s12 <= tmax_s11;
			go_s12   <= go_s11;
			bm_s12   <= bm_s11;
			v2_s12   <= v2_s11;
			pos_s12  <= bb_s11 + vf_s11;
			neg_s12  <= vr_s11;

			// s13: discriminant, seeds the root
			sq_s[0].hit  <= go_s12 && !dif_c[128];
			sq_s[0].bm   <= bm_s12;
			sq_s[0].v2   <= v2_s12;
			sq_s[0].tmax <= tmax_s12;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].n    <= dif_c[127:0];
		end
	end

	// ---------------- square root, one bit per stage ----------------
	for (genvar k = 1; k <= 64; k++) begin : g_sq
		logic [67:0] r4, trial, diff;
		logic        ge;

		always_comb begin
			r4    = {sq_s[k-1].rem, sq_s[k-1].n[127:126]};
			trial = {2'b00, sq_s[k-1].root, 2'b01};
			diff  = r4 - trial;
			ge    = r4 >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[k] <= 1'b0;
			else if (en)
				sq_v[k] <= sq_v[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k].hit  <= sq_s[k-1].hit;
				sq_s[k].bm   <= sq_s[k-1].bm;
				sq_s[k].v2   <= sq_s[k-1].v2;
				sq_s[k].tmax <= sq_s[k-1].tmax;
				sq_s[k].rem  <= ge ? diff[65:0] : r4[65:0];
				sq_s[k].root <= {sq_s[k-1].root[62:0], ge};
				sq_s[k].n    <= {sq_s[k-1].n[125:0], 2'b00};
			end
		end
	end

	// ---------------- divider setup ----------------
	logic        fwd_c;
	logic [63:0] dn_c;

	always_comb begin
		fwd_c = {1'b0, sq_s[64].bm} >= sq_s[64].root;
		dn_c  = fwd_c ? {1'b0, sq_s[64].bm} - sq_s[64].root
			: sq_s[64].root - {1'b0, sq_s[64].bm};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v[0] <= 1'b0;
		else if (en)
			dv_v[0] <= sq_v[64];
	end

	// numerator is dn << 16; quotient bits above bit 40 only mean saturation
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].hit  <= sq_s[64].hit;
			dv_s[0].fwd  <= fwd_c;
			dv_s[0].ovq  <= {24'd0, dn_c[63:25]} >= sq_s[64].v2;
			dv_s[0].v2   <= sq_s[64].v2;
			dv_s[0].tmax <= sq_s[64].tmax;
			dv_s[0].rem  <= {24'd0, dn_c[63:25]};
			dv_s[0].q    <= '0;
			dv_s[0].nb   <= {dn_c[24:0], 16'd0};
		end
	end

	// ---------------- restoring divider, one bit per stage ----------------
	for (genvar k = 1; k <= 41; k++) begin : g_dv
		logic [63:0] t, diff;
		logic        ge;

		always_comb begin
			t    = {dv_s[k-1].rem, dv_s[k-1].nb[40]};
			diff = t - {1'b0, dv_s[k-1].v2};
			ge   = t >= {1'b0, dv_s[k-1].v2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v[k] <= 1'b0;
			else if (en)
				dv_v[k] <= dv_v[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k].hit  <= dv_s[k-1].hit;
				dv_s[k].fwd  <= dv_s[k-1].fwd;
				dv_s[k].ovq  <= dv_s[k-1].ovq;
				dv_s[k].v2   <= dv_s[k-1].v2;
				dv_s[k].tmax <= dv_s[k-1].tmax;
				dv_s[k].rem  <= ge ? diff[62:0] : t[62:0];
				dv_s[k].q    <= {dv_s[k-1].q[39:0], ge};
				dv_s[k].nb   <= {dv_s[k-1].nb[39:0], 1'b0};
			end
		end
	end

	// ---------------- final time ----------------
	logic        v_s120;
	out_word_t   res_s120;
	out_word_t   res_c;
	logic [40:0] qs_c;
	logic [41:0] sum_c;

	always_comb begin
		qs_c  = (dv_s[41].ovq || (dv_s[41].q[40] && (dv_s[41].q[39:0] != '0)))
			? QS_SAT : dv_s[41].q;
		sum_c = {2'b00, dv_s[41].tmax} + {1'b0, qs_c};
		res_c = '0;
		if (dv_s[41].hit) begin
			res_c.hit = 1'b1;
			if (dv_s[41].fwd) begin
				if (sum_c > {2'b00, TIME_MAX}) begin
					res_c.contact_time  = TIME_MAX;
					res_c.time_overflow = 1'b1;
				end else begin
					res_c.contact_time = sum_c[39:0];
				end
			end else if (qs_c > {1'b0, dv_s[41].tmax}) begin
				res_c.contact_time = '0;
			end else begin
				res_c.contact_time = dv_s[41].tmax - qs_c[39:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s120 <= 1'b0;
		else if (en)
			v_s120 <= dv_v[41];
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s120 <= res_c;
	end

	// ---------------- output register and skid slot ----------------
	logic      out_valid_q;
	out_word_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_stall)
				skid_v_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= v_s120;
		end else if (v_s120) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_stall)
				out_q <= skid_q;
		end else if (!out_valid_q || !out_stall) begin
			out_q <= res_s120;
		end else begin
			skid_q <= res_s120;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- checks ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skid_v_q) |-> $past(!out_stall))
		else $error("skid word released without output transfer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.hit |-> out_q.contact_time == '0 && !out_q.time_overflow)
		else $error("miss word carries a time");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.time_overflow |-> out_q.hit && (&out_q.contact_time))
		else $error("overflow without saturated hit time");

endmodule
